FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the fBm gradient noise block.
// Depends on nothing; every user names its clock clock and its reset reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GNF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GNF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/gnf_pkg.sv
// Package of the fBm gradient noise block: constants, register indexes and
// the control structs between the top level and the divider. No dependencies.
package gnf_pkg;

   localparam int MAX_OCTAVES_DEF     = 8;
   localparam int COORD_FRAC_BITS_DEF = 16;

   localparam logic [31:0] GOLDEN = 32'h9e3779b9;
   localparam logic [31:0] MIX_C1 = 32'h85ebca6b;
   localparam logic [31:0] MIX_C2 = 32'hc2b2ae35;

   localparam int INV_SQRT2_Q16 = 46341;
   localparam int SQRT2_Q16     = 92682;
   localparam int ONE_Q16       = 65536;
   localparam int FADE_C15      = 15 * 65536;
   localparam int FADE_C10      = 10 * 65536;

   // Shared multiplier operand and product widths.
   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVES    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LACUNARITY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN       = 3'd3;

   typedef struct packed {
      logic start;
   } gnf_div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } gnf_div_sts_type;

endpackage

FILE: sv/gnf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gnf_pkg for its control and status structs.
module gnf_div
   import gnf_pkg::*;
#(
   parameter int NUM_W = 58,
   parameter int DEN_W = 37
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gnf_div_ctl_type       ctl,
   input  logic [NUM_W-1:0]      num,
   input  logic [DEN_W-1:0]      den,
   output gnf_div_sts_type       sts,
   output logic [NUM_W-1:0]      quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // The dividend shifts out of the top of q_ff while quotient bits enter below.
   assign trial = {rem_ff, q_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         den_in  = den;
         q_in    = num;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         q_in   = {q_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot     = q_ff;

endmodule

FILE: sv/gradient_noise_fbm_2d_top.sv
// Top level of the fBm 2D gradient noise block: sequencer around one shared
// multiplier, plus the divider. Depends on gnf_pkg, gnf_div, assert_macros.svh.
//
// Usage: a point (req_coord_x, req_coord_z, signed fixed point with
// COORD_FRAC_BITS fraction bits) is taken on the req_ word channel when
// req_valid and req_ready are high; one word rsp_noise_value (Q0.15) comes
// back on the rsp_ channel. The block works on one point at a time and drops
// req_ready from acceptance until the result sits in the output register.
// Each octave is paced by the one shared multiplier: splitting the
// coordinates, the two fade curves, hash and gradient for each lattice
// corner, then blending and accumulation. The final normalization runs a
// bit-serial divider over SUM_W quotient bits (58 when MAX_OCTAVES is 8);
// zero octaves gives 0. The output register frees the core: a new point may
// be taken while a result waits, and a stalled rsp_ready only holds the core
// once the next result is ready. Reset is synchronous and restores seed 0,
// four octaves, lacunarity 2.0 and gain 0.5; csr_ writes take effect at
// once. The user must make them only while the block is idle; the block
// itself does not enforce this.
module gradient_noise_fbm_2d_top
   import gnf_pkg::*;
#(
   parameter int MAX_OCTAVES     = MAX_OCTAVES_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [31:0]    req_coord_x,
   input  logic signed [31:0]    req_coord_z,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [15:0]    rsp_noise_value,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "assert_macros.svh"

   localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
   localparam int SUM_W  = 54 + OCT_W;
   localparam int NORM_W = 32 + OCT_W;
   localparam int DEN_W  = NORM_W + 1;
   localparam int FR_LO  = 12;
   localparam int CL_LO  = 12 + COORD_FRAC_BITS;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SPLIT = 7'b0000010,
      S_FADE  = 7'b0000100,
      S_HASH  = 7'b0001000,
      S_BLEND = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   // Configuration registers.
   logic [31:0] seed_ff;
   logic [3:0]  octave_count_ff;
   logic [15:0] lacunarity_ff;
   logic [15:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff         <= '0;
         octave_count_ff <= 4'd4;
         lacunarity_ff   <= 16'd8192;
         gain_ff         <= 16'd2048;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SEED:       seed_ff         <= csr_wdata;
            CSR_OCTAVES:    octave_count_ff <= csr_wdata[3:0];
            CSR_LACUNARITY: lacunarity_ff   <= csr_wdata[15:0];
            CSR_GAIN:       gain_ff         <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   state_type                state_ff, state_in;
   logic [2:0]               sub_ff, sub_in;
   logic [1:0]               corner_ff, corner_in;
   logic [OCT_W-1:0]         oct_left_ff, oct_left_in;
   logic signed [31:0]       x_ff, x_in, z_ff, z_in;
   logic [31:0]              freq_ff, freq_in, amp_ff, amp_in;
   logic [31:0]              cx_ff, cx_in, cz_ff, cz_in;
   logic [15:0]              tx_ff, tx_in, tz_ff, tz_in;
   logic [16:0]              t2_ff, t2_in, t3_ff, t3_in;
   logic [20:0]              m_ff, m_in;
   logic [16:0]              u_ff, u_in, v_ff, v_in;
   logic [31:0]              h_ff, h_in;
   logic signed [18:0]       n_ff [4];
   logic signed [18:0]       n_wr;
   logic                     n_we;
   logic signed [19:0]       a_ff, a_in, b_ff, b_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [NORM_W-1:0]        norm_ff, norm_in;
   logic [SUM_W-1:0]         q_ff, q_in;
   logic                     neg_ff, neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]       rsp_value_ff, rsp_value_in;

   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [PROD_W-1:0] prod;
   logic [PROD_W-13:0]       prod_q12;
   logic [15:0]              t_sel;
   logic [31:0]              cxc, czc, hmix;
   logic [2:0]               grad_k;
   logic signed [17:0]       dx, dz;
   logic signed [18:0]       dot_s;
   logic signed [19:0]       diff;
   logic [OCT_W-1:0]         n_oct;
   logic [COORD_FRAC_BITS+15:0] frac_wide;

   gnf_div_ctl_type          div_ctl;
   gnf_div_sts_type          div_sts;
   logic [SUM_W-1:0]         div_num, div_quot;
   logic [DEN_W-1:0]         div_den;

   // Dot product with one of eight gradients; diagonals still need 1/sqrt(2).
   function automatic logic signed [18:0] grad_sum(input logic [2:0] k,
                                                   input logic signed [17:0] gx,
                                                   input logic signed [17:0] gz);
      logic signed [18:0] ex;
      logic signed [18:0] ez;
      ex = 19'(gx);
      ez = 19'(gz);
      case (k)
         3'd0:    grad_sum = ex;
         3'd1:    grad_sum = ex + ez;
         3'd2:    grad_sum = ez;
         3'd3:    grad_sum = ez - ex;
         3'd4:    grad_sum = -ex;
         3'd5:    grad_sum = -ex - ez;
         3'd6:    grad_sum = -ez;
         default: grad_sum = ex - ez;
      endcase
   endfunction

   assign n_oct = (32'(octave_count_ff) > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES)
                                                        : OCT_W'(octave_count_ff);
   assign t_sel  = sub_ff[2] ? tz_ff : tx_ff;
   assign cxc    = cx_ff + 32'(corner_ff[0]);
   assign czc    = cz_ff + 32'(corner_ff[1]);
   assign grad_k = h_ff[2:0] ^ h_ff[18:16];
   assign dx     = $signed({2'b00, tx_ff}) - (corner_ff[0] ? 18'sd65536 : 18'sd0);
   assign dz     = $signed({2'b00, tz_ff}) - (corner_ff[1] ? 18'sd65536 : 18'sd0);
   assign dot_s  = grad_sum(grad_k, dx, dz);

   always_comb begin
      case (sub_ff)
         3'd0:    diff = 20'(n_ff[1]) - 20'(n_ff[0]);
         3'd1:    diff = 20'(n_ff[3]) - 20'(n_ff[2]);
         default: diff = b_ff - a_ff;
      endcase
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         S_SPLIT: begin
            op_a = sub_ff[0] ? MUL_W'(z_ff) : MUL_W'(x_ff);
            op_b = MUL_W'(freq_ff);
         end
         S_FADE: begin
            case (sub_ff[1:0])
               2'd0: begin
                  op_a = MUL_W'(t_sel);
                  op_b = MUL_W'(t_sel);
               end
               2'd1: begin
                  op_a = MUL_W'(t2_ff);
                  op_b = MUL_W'(t_sel);
               end
               2'd2: begin
                  op_a = MUL_W'(t_sel);
                  op_b = MUL_W'(FADE_C15) - MUL_W'({t_sel, 2'b00}) - MUL_W'({t_sel, 1'b0});
               end
               default: begin
                  op_a = MUL_W'(t3_ff);
                  op_b = MUL_W'(FADE_C10) - MUL_W'(m_ff);
               end
            endcase
         end
         S_HASH: begin
            case (sub_ff)
               3'd2: begin
                  op_a = MUL_W'(h_ff ^ (h_ff >> 16));
                  op_b = MUL_W'(MIX_C1);
               end
               3'd3: begin
                  op_a = MUL_W'(h_ff ^ (h_ff >> 13));
                  op_b = MUL_W'(MIX_C2);
               end
               default: begin
                  op_a = MUL_W'(dot_s);
                  op_b = MUL_W'(INV_SQRT2_Q16);
               end
            endcase
         end
         S_BLEND: begin
            case (sub_ff)
               3'd0, 3'd1: begin
                  op_a = MUL_W'(u_ff);
                  op_b = MUL_W'(diff);
               end
               3'd2: begin
                  op_a = MUL_W'(v_ff);
                  op_b = MUL_W'(diff);
               end
               3'd3: begin
                  op_a = MUL_W'(a_ff);
                  op_b = MUL_W'(SQRT2_Q16);
               end
               3'd4: begin
                  op_a = MUL_W'(amp_ff);
                  op_b = MUL_W'(a_ff);
               end
               3'd5: begin
                  op_a = MUL_W'(amp_ff);
                  op_b = MUL_W'(gain_ff);
               end
               default: begin
                  op_a = MUL_W'(freq_ff);
                  op_b = MUL_W'(lacunarity_ff);
               end
            endcase
         end
         default: ;
      endcase
   end

   assign prod      = op_a * op_b;
   assign prod_q12  = prod[PROD_W-1:12];
   assign frac_wide = {prod[CL_LO-1:FR_LO], 16'h0000};
   assign hmix      = GOLDEN + (h_ff << 6) + (h_ff >> 2);

   always_comb begin
      state_in     = state_ff;
      sub_in       = sub_ff;
      corner_in    = corner_ff;
      oct_left_in  = oct_left_ff;
      x_in         = x_ff;
      z_in         = z_ff;
      freq_in      = freq_ff;
      amp_in       = amp_ff;
      cx_in        = cx_ff;
      cz_in        = cz_ff;
      tx_in        = tx_ff;
      tz_in        = tz_ff;
      t2_in        = t2_ff;
      t3_in        = t3_ff;
      m_in         = m_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      h_in         = h_ff;
      n_we         = 1'b0;
      n_wr         = dot_s;
      a_in         = a_ff;
      b_in         = b_ff;
      sum_in       = sum_ff;
      norm_in      = norm_ff;
      q_in         = q_ff;
      neg_in       = neg_ff;
      div_ctl      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in        = req_coord_x;
               z_in        = req_coord_z;
               freq_in     = 32'd4096;
               amp_in      = 32'd4096;
               sum_in      = '0;
               norm_in     = '0;
               oct_left_in = n_oct;
               sub_in      = '0;
               corner_in   = '0;
               if (n_oct == '0) begin
                  q_in     = '0;
                  neg_in   = 1'b0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_SPLIT;
               end
            end
         end
         S_SPLIT: begin
            // Cell index and fraction of floor(coord * freq / 4096).
            if (sub_ff[0]) begin
               cz_in    = prod[CL_LO+31:CL_LO];
               tz_in    = frac_wide[COORD_FRAC_BITS+15:COORD_FRAC_BITS];
               sub_in   = '0;
               state_in = S_FADE;
            end else begin
               cx_in  = prod[CL_LO+31:CL_LO];
               tx_in  = frac_wide[COORD_FRAC_BITS+15:COORD_FRAC_BITS];
               sub_in = 3'd1;
            end
         end
         S_FADE: begin
            sub_in = sub_ff + 1'b1;
            case (sub_ff[1:0])
               2'd0: t2_in = 17'(prod >>> 16);
               2'd1: t3_in = 17'(prod >>> 16);
               2'd2: m_in  = 21'(prod >>> 16);
               default: begin
                  if (sub_ff[2]) begin
                     v_in     = 17'(prod >>> 16);
                     sub_in   = '0;
                     state_in = S_HASH;
                  end else begin
                     u_in = 17'(prod >>> 16);
                  end
               end
            endcase
         end
         S_HASH: begin
            sub_in = sub_ff + 1'b1;
            case (sub_ff)
               3'd0: h_in = seed_ff ^ (cxc + GOLDEN + (seed_ff << 6) + (seed_ff >> 2));
               3'd1: h_in = h_ff ^ (czc + hmix);
               3'd2, 3'd3: h_in = prod[31:0];
               default: begin
                  n_we   = 1'b1;
                  n_wr   = grad_k[0] ? 19'(prod >>> 16) : dot_s;
                  sub_in = '0;
                  corner_in = corner_ff + 1'b1;
                  if (corner_ff == 2'd3) begin
                     state_in = S_BLEND;
                  end
               end
            endcase
         end
         S_BLEND: begin
            sub_in = sub_ff + 1'b1;
            case (sub_ff)
               3'd0: a_in = 20'(n_ff[0]) + 20'(prod >>> 16);
               3'd1: b_in = 20'(n_ff[2]) + 20'(prod >>> 16);
               3'd2: a_in = a_ff + 20'(prod >>> 16);
               3'd3: a_in = 20'(prod >>> 16);
               3'd4: begin
                  sum_in  = sum_ff + SUM_W'(prod);
                  norm_in = norm_ff + NORM_W'(amp_ff);
               end
               3'd5: amp_in = (|prod_q12[PROD_W-13:32]) ? 32'hFFFF_FFFF : prod_q12[31:0];
               default: begin
                  freq_in = (|prod_q12[PROD_W-13:32]) ? 32'hFFFF_FFFF : prod_q12[31:0];
                  oct_left_in = oct_left_ff - 1'b1;
                  sub_in      = '0;
                  state_in    = (oct_left_ff == OCT_W'(1)) ? S_DIV : S_SPLIT;
               end
            endcase
         end
         S_DIV: begin
            if (sub_ff == 3'd0) begin
               div_ctl.start = 1'b1;
               neg_in        = sum_ff[SUM_W-1];
               sub_in        = 3'd1;
            end else if (div_sts.done) begin
               q_in     = div_quot;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_value_in = (q_ff > SUM_W'(32768)) ? -16'sd32768 : 16'(-q_ff);
               end else begin
                  rsp_value_in = (q_ff > SUM_W'(32767)) ? 16'sd32767 : 16'(q_ff);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign div_num = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign div_den = {norm_ff, 1'b0};

   gnf_div #(
      .NUM_W (SUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (div_den),
      .sts   (div_sts),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sub_ff       <= '0;
         corner_ff    <= '0;
         oct_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sub_ff       <= sub_in;
         corner_ff    <= corner_in;
         oct_left_ff  <= oct_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      z_ff         <= z_in;
      freq_ff      <= freq_in;
      amp_ff       <= amp_in;
      cx_ff        <= cx_in;
      cz_ff        <= cz_in;
      tx_ff        <= tx_in;
      tz_ff        <= tz_in;
      t2_ff        <= t2_in;
      t3_ff        <= t3_in;
      m_ff         <= m_in;
      u_ff         <= u_in;
      v_ff         <= v_in;
      h_ff         <= h_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      sum_ff       <= sum_in;
      norm_ff      <= norm_in;
      q_ff         <= q_in;
      neg_ff       <= neg_in;
      rsp_value_ff <= rsp_value_in;
      if (n_we) begin
         n_ff[corner_ff] <= n_wr;
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

   `GNF_ASSERT_NEXT(a_zero_oct, req_valid && req_ready && (n_oct == '0), (state_ff == S_OUT) && (q_ff == '0), "zero octaves must go straight to output with zero")
   `GNF_ASSERT_SAME(a_idle_oct, state_ff == S_IDLE, oct_left_ff == '0, "octave counter not drained in idle")
   `GNF_ASSERT_SAME(a_div_done, div_sts.done, state_ff == S_DIV, "divider finished outside the divide step")
   `GNF_ASSERT_NEXT(a_last_corner, (state_ff == S_HASH) && (sub_ff == 3'd4) && (corner_ff == 2'd3), (state_ff == S_BLEND) && (corner_ff == 2'd0), "blend must follow the fourth corner")

endmodule
